// ----- src/fmtrf_pkg.sv -----
// Shared types, constants and load functions of the timer register file.
package fmtrf_pkg;

  localparam int unsigned BusyTicks    = 50;
  localparam int unsigned TimerOneUnit = 80;
  localparam int unsigned TimerTwoUnit = 320;
  localparam int unsigned RegCount     = 256;

  localparam int unsigned AddrW     = 8;
  localparam int unsigned DataW     = 8;
  localparam int unsigned RegIdxW   = $clog2(RegCount);
  localparam int unsigned BusyW     = 6;
  localparam int unsigned TimerOneW = 15;
  localparam int unsigned TimerTwoW = 17;
  localparam int unsigned SpanW     = 9;
  localparam int unsigned ProdW     = 18;

  localparam logic [BusyW-1:0] BusyLoad = BusyW'(BusyTicks);

  localparam logic [AddrW-1:0] RegTimerOne  = 8'h02;
  localparam logic [AddrW-1:0] RegTimerTwo  = 8'h03;
  localparam logic [AddrW-1:0] RegTimerCtrl = 8'h04;

  localparam int unsigned CtrlStartOne = 0;
  localparam int unsigned CtrlStartTwo = 1;
  localparam int unsigned CtrlClrOne   = 5;
  localparam int unsigned CtrlClrTwo   = 6;
  localparam int unsigned CtrlReset    = 7;

  localparam int unsigned FlagOne = 1;
  localparam int unsigned FlagTwo = 0;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  typedef enum logic {
    PORT_ADDR = 1'b0,
    PORT_DATA = 1'b1
  } port_e;

  typedef struct packed {
    mode_e            mode;
    port_e            port_select;
    logic [DataW-1:0] data;
  } item_t;

  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [DataW-1:0]   data;
  } mem_wr_t;

  function automatic logic [TimerOneW-1:0] timer_one_load(input logic [DataW-1:0] v);
    logic [SpanW-1:0] span;
    logic [ProdW-1:0] prod;
    span = SpanW'(256) - SpanW'(v);
    prod = ProdW'(span) * ProdW'(TimerOneUnit);
    return prod[TimerOneW-1:0];
  endfunction

  function automatic logic [TimerTwoW-1:0] timer_two_load(input logic [DataW-1:0] v);
    logic [SpanW-1:0] span;
    logic [ProdW-1:0] prod;
    span = SpanW'(256) - SpanW'(v);
    prod = ProdW'(span) * ProdW'(TimerTwoUnit);
    return prod[TimerTwoW-1:0];
  endfunction

endpackage

// ----- src/fmtrf_req_if.sv -----
// Request channel: tick, read or write item with valid/ready handshake.
interface fmtrf_req_if;
  import fmtrf_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic             port_select;
  logic [DataW-1:0] data;

  modport source (output valid, output mode, output port_select, output data, input ready);
  modport sink (input valid, input mode, input port_select, input data, output ready);
endinterface

// ----- src/fmtrf_rsp_if.sv -----
// Response channel: read data with valid/ready handshake.
interface fmtrf_rsp_if;
  import fmtrf_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

// ----- src/fmtrf_reg_mem.sv -----
// Register file memory with per-entry valid bits and registered read.
module fmtrf_reg_mem (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fmtrf_pkg::mem_wr_t       wr_i,
  input  logic                     rd_en_i,
  input  logic                     rd_hit_i,
  input  logic [fmtrf_pkg::RegIdxW-1:0] rd_idx_i,
  output logic [fmtrf_pkg::DataW-1:0]   rd_data_o
);
  import fmtrf_pkg::*;

  logic [DataW-1:0] mem_q [RegCount];
  logic [RegCount-1:0] entry_valid_q;
  logic [DataW-1:0] rd_q;
  logic             rd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      rd_hit_q      <= 1'b0;
    end else begin
      if (wr_i.en) begin
        entry_valid_q[wr_i.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= rd_hit_i && entry_valid_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rd_hit_q ? rd_q : '0;
endmodule

// ----- src/fmtrf_ctrl.sv -----
// Address latch, busy countdown, timers, overflow flags and status byte.
module fmtrf_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_fire_i,
  input  fmtrf_pkg::item_t            item_i,
  output logic [fmtrf_pkg::DataW-1:0] status_o,
  output logic [fmtrf_pkg::AddrW-1:0] addr_o,
  output logic                        addr_hit_o,
  output fmtrf_pkg::mem_wr_t          mem_wr_o
);
  import fmtrf_pkg::*;

  logic [AddrW-1:0]     addr_q, addr_d;
  logic [1:0]           flags_q, flags_d;
  logic [BusyW-1:0]     busy_q, busy_d;
  logic [TimerOneW-1:0] t1_cnt_q, t1_cnt_d;
  logic                 t1_arm_q, t1_arm_d;
  logic [TimerTwoW-1:0] t2_cnt_q, t2_cnt_d;
  logic                 t2_arm_q, t2_arm_d;
  logic [DataW-1:0]     reg2_q, reg2_d;
  logic [DataW-1:0]     reg3_q, reg3_d;
  logic [DataW-1:0]     reg4_q, reg4_d;
  logic                 is_tick, is_read, is_write;

  assign addr_o     = addr_q;
  assign addr_hit_o = ({1'b0, addr_q} < (AddrW + 1)'(RegCount));

  always_comb begin
    is_tick  = 1'b0;
    is_read  = 1'b0;
    is_write = 1'b0;
    unique case (item_i.mode)
      MODE_TICK:  is_tick  = req_fire_i;
      MODE_READ:  is_read  = req_fire_i;
      MODE_WRITE: is_write = req_fire_i;
      default: ;
    endcase
  end

  always_comb begin
    addr_d   = addr_q;
    flags_d  = flags_q;
    busy_d   = busy_q;
    t1_cnt_d = t1_cnt_q;
    t1_arm_d = t1_arm_q;
    t2_cnt_d = t2_cnt_q;
    t2_arm_d = t2_arm_q;
    reg2_d   = reg2_q;
    reg3_d   = reg3_q;
    reg4_d   = reg4_q;
    mem_wr_o = '{en: 1'b0, idx: addr_q[RegIdxW-1:0], data: item_i.data};

    if (is_tick) begin
      if (busy_q != '0) busy_d = busy_q - 1'b1;
      if (t1_arm_q && t1_cnt_q != '0) t1_cnt_d = t1_cnt_q - 1'b1;
      if (t2_arm_q && t2_cnt_q != '0) t2_cnt_d = t2_cnt_q - 1'b1;
    end

    if (is_read && item_i.port_select == PORT_ADDR) begin
      if (t1_arm_q && t1_cnt_q == '0) begin
        flags_d[FlagOne] = 1'b1;
        t1_arm_d         = 1'b0;
      end
      if (t2_arm_q && t2_cnt_q == '0) begin
        flags_d[FlagTwo] = 1'b1;
        t2_arm_d         = 1'b0;
      end
    end

    if (is_write) begin
      busy_d = BusyLoad;
      if (item_i.port_select == PORT_ADDR) begin
        addr_d = item_i.data;
      end else begin
        mem_wr_o.en = addr_hit_o;
        if (addr_q == RegTimerCtrl) begin
          reg4_d = item_i.data;
          if (item_i.data[CtrlReset]) flags_d = '0;
          if (item_i.data[CtrlClrOne]) flags_d[FlagOne] = 1'b0;
          if (item_i.data[CtrlClrTwo]) flags_d[FlagTwo] = 1'b0;
          if (item_i.data[CtrlStartOne]) begin
            t1_cnt_d = timer_one_load(reg2_q);
            t1_arm_d = 1'b1;
          end else begin
            t1_arm_d = 1'b0;
          end
          if (item_i.data[CtrlStartTwo]) begin
            t2_cnt_d = timer_two_load(reg3_q);
            t2_arm_d = 1'b1;
          end else begin
            t2_arm_d = 1'b0;
          end
        end else if (addr_q == RegTimerOne) begin
          reg2_d = item_i.data;
          if (reg4_q[CtrlStartOne]) begin
            t1_cnt_d = timer_one_load(item_i.data);
            t1_arm_d = 1'b1;
          end
        end else if (addr_q == RegTimerTwo) begin
          reg3_d = item_i.data;
          if (reg4_q[CtrlStartTwo]) begin
            t2_cnt_d = timer_two_load(item_i.data);
            t2_arm_d = 1'b1;
          end
        end
      end
    end

    status_o = {flags_d[FlagOne], flags_d[FlagTwo], 5'b0, (busy_q != '0)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      flags_q  <= '0;
      busy_q   <= '0;
      t1_cnt_q <= '0;
      t1_arm_q <= 1'b0;
      t2_cnt_q <= '0;
      t2_arm_q <= 1'b0;
      reg2_q   <= '0;
      reg3_q   <= '0;
      reg4_q   <= '0;
    end else begin
      addr_q   <= addr_d;
      flags_q  <= flags_d;
      busy_q   <= busy_d;
      t1_cnt_q <= t1_cnt_d;
      t1_arm_q <= t1_arm_d;
      t2_cnt_q <= t2_cnt_d;
      t2_arm_q <= t2_arm_d;
      reg2_q   <= reg2_d;
      reg3_q   <= reg3_d;
      reg4_q   <= reg4_d;
    end
  end
endmodule

// ----- src/fm_chip_timer_register_file.sv -----
// Top level of the sound chip timer and status register front end.
//
// Usage:
//   req_i carries one request per handshake: a one-microsecond tick, a port
//   read or a port write (mode, port_select, data). rsp_o returns read_data
//   for each read request only; ticks and writes give no response.
//   Port 0 write latches the register address, port 1 write stores data in
//   the 256-byte register file; register 4 controls the two timers.
//   Port 0 read returns the status byte (timer flags in bits 7 and 6, busy
//   in bit 0); port 1 read returns the addressed register.
// Read response: rsp_o.valid is registered, set in the cycle after its request is taken.
// Throughput: one request per cycle unless a response stalls; the response register
//   is the only stage, and a new request is taken in the same cycle the pending
//   response is taken.
// Reset: all registers, flags, timers and the busy count clear; the register
//   file reads as zero until written, with no clearing pass.
// Stall: while a response waits and rsp_o.ready is low, req_i.ready is low
//   and the response holds.
module fm_chip_timer_register_file (
  input logic        clk_i,
  input logic        rst_ni,
  fmtrf_req_if.sink   req_i,
  fmtrf_rsp_if.source rsp_o
);
  import fmtrf_pkg::*;

  item_t            item;
  logic             req_fire;
  logic             read_fire;
  logic             rd_en;
  logic [DataW-1:0] status;
  logic [AddrW-1:0] addr;
  logic             addr_hit;
  mem_wr_t          mem_wr;
  logic [DataW-1:0] mem_rd;
  logic             out_valid_q;
  logic             sel_data_q;
  logic [DataW-1:0] status_q;

  assign item        = '{mode: mode_e'(req_i.mode), port_select: port_e'(req_i.port_select),
                         data: req_i.data};
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign read_fire   = req_fire && (item.mode == MODE_READ);
  assign rd_en       = read_fire && (item.port_select == PORT_DATA);

  fmtrf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_fire_i (req_fire),
    .item_i     (item),
    .status_o   (status),
    .addr_o     (addr),
    .addr_hit_o (addr_hit),
    .mem_wr_o   (mem_wr)
  );

  fmtrf_reg_mem u_reg_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mem_wr),
    .rd_en_i   (rd_en),
    .rd_hit_i  (addr_hit),
    .rd_idx_i  (addr[RegIdxW-1:0]),
    .rd_data_o (mem_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (read_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (read_fire) begin
      sel_data_q <= (item.port_select == PORT_DATA);
      status_q   <= status;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = sel_data_q ? mem_rd : status_q;
endmodule

// ----- verif/fm_chip_timer_register_file_tb.sv -----
// Testbench for the timer register file: directed and random requests checked by a predictor.
`timescale 1ns / 1ps

module fm_chip_timer_register_file_tb;
  import fmtrf_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned ItemTarget = 1750;
  localparam int unsigned RandPhases = 3;
  localparam int unsigned CycleLimit = 400000;

  class timer_regs_board;
    logic [DataW-1:0]     regs [RegCount];
    logic [AddrW-1:0]     addr;
    logic [1:0]           flags;
    logic [BusyW-1:0]     busy;
    logic [TimerOneW-1:0] one_count;
    logic [TimerTwoW-1:0] two_count;
    bit                   one_armed;
    bit                   two_armed;
    logic [DataW-1:0]     pending_reads [$];
    int unsigned          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      addr = '0;
      flags = '0;
      busy = '0;
      one_count = '0;
      two_count = '0;
      one_armed = 1'b0;
      two_armed = 1'b0;
      errors = 0;
    endfunction

    function logic [DataW-1:0] reg_at(logic [AddrW-1:0] a);
      return (a < RegCount) ? regs[a] : '0;
    endfunction

    function logic [TimerOneW-1:0] one_span(logic [DataW-1:0] v);
      int unsigned span;
      span = 256 - v;
      return TimerOneW'(span * TimerOneUnit);
    endfunction

    function logic [TimerTwoW-1:0] two_span(logic [DataW-1:0] v);
      int unsigned span;
      span = 256 - v;
      return TimerTwoW'(span * TimerTwoUnit);
    endfunction

    function void store_data(logic [DataW-1:0] v);
      logic [DataW-1:0] ctrl;
      if (addr < RegCount) regs[addr] = v;
      busy = BusyLoad;
      ctrl = reg_at(RegTimerCtrl);
      if (addr == RegTimerCtrl) begin
        if (v[CtrlReset]) begin
          flags = '0;
          one_armed = 1'b0;
          two_armed = 1'b0;
        end
        if (v[CtrlClrOne]) flags[FlagOne] = 1'b0;
        if (v[CtrlClrTwo]) flags[FlagTwo] = 1'b0;
        if (v[CtrlStartOne]) begin
          one_count = one_span(reg_at(RegTimerOne));
          one_armed = 1'b1;
        end else begin
          one_armed = 1'b0;
        end
        if (v[CtrlStartTwo]) begin
          two_count = two_span(reg_at(RegTimerTwo));
          two_armed = 1'b1;
        end else begin
          two_armed = 1'b0;
        end
      end else if (addr == RegTimerOne) begin
        if (ctrl[CtrlStartOne]) begin
          one_count = one_span(v);
          one_armed = 1'b1;
        end
      end else if (addr == RegTimerTwo) begin
        if (ctrl[CtrlStartTwo]) begin
          two_count = two_span(v);
          two_armed = 1'b1;
        end
      end
    endfunction

    function logic [DataW-1:0] status_byte();
      if (one_armed && one_count == 0) begin
        flags[FlagOne] = 1'b1;
        one_armed = 1'b0;
      end
      if (two_armed && two_count == 0) begin
        flags[FlagTwo] = 1'b1;
        two_armed = 1'b0;
      end
      return {flags[FlagOne], flags[FlagTwo], 5'b0, busy != 0};
    endfunction

    function void note_request(logic [1:0] mode, logic port, logic [DataW-1:0] data);
      case (mode)
        MODE_TICK: begin
          if (busy != 0) busy--;
          if (one_armed && one_count != 0) one_count--;
          if (two_armed && two_count != 0) two_count--;
        end
        MODE_READ: begin
          if (port == PORT_ADDR) pending_reads.push_back(status_byte());
          else pending_reads.push_back(reg_at(addr));
        end
        MODE_WRITE: begin
          if (port == PORT_ADDR) begin
            addr = data;
            busy = BusyLoad;
          end else begin
            store_data(data);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_read(logic [DataW-1:0] got);
      logic [DataW-1:0] want;
      if (pending_reads.size() == 0) begin
        $error("read_data %02h arrived with no read pending", got);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        if (got !== want) begin
          $error("read_data mismatch: expected %02h actual %02h", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fmtrf_req_if req_if ();
  fmtrf_rsp_if rsp_if ();

  fm_chip_timer_register_file i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  timer_regs_board board = new();
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(posedge clk_i) rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) board.check_read(rsp_if.read_data);
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("fm_chip_timer_register_file_tb failed");
    $finish;
  end

  task automatic send_request(input logic [1:0] mode, input logic port,
                              input logic [DataW-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      req_if.data <= DataW'($urandom);
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= mode;
    req_if.port_select <= port;
    req_if.data <= data;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    board.note_request(mode, port, data);
    if (mode != ModeUnused) items_sent++;
  endtask

  task automatic write_reg(input logic [AddrW-1:0] a, input logic [DataW-1:0] v);
    send_request(MODE_WRITE, PORT_ADDR, a);
    send_request(MODE_WRITE, PORT_DATA, v);
  endtask

  // hold off new requests until every pending read has returned
  task automatic drain_reads();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending_reads.size() != 0);
  endtask

  function automatic logic [AddrW-1:0] pick_addr();
    case ($urandom_range(3))
      0: return AddrW'($urandom);
      1: return AddrW'($urandom_range(RegTimerOne, RegTimerCtrl));
      2: return $urandom_range(1) ? AddrW'(0) : AddrW'(255);
      default: return AddrW'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic run_timers();
    logic [DataW-1:0] ctrl;
    int unsigned n;
    ctrl = DataW'($urandom);
    ctrl[CtrlStartOne] = ($urandom_range(3) != 0);
    ctrl[CtrlStartTwo] = ($urandom_range(3) != 0);
    if ($urandom_range(3) != 0) ctrl[CtrlReset] = 1'b0;
    write_reg(RegTimerOne, DataW'($urandom_range(8'hFB, 8'hFF)));
    write_reg(RegTimerTwo, DataW'($urandom_range(8'hFD, 8'hFF)));
    write_reg(RegTimerCtrl, ctrl);
    n = $urandom_range(80, 500);
    repeat (n) begin
      if ($urandom_range(19) == 0) send_request(MODE_READ, PORT_ADDR, DataW'($urandom));
      else send_request(MODE_TICK, 1'($urandom), DataW'($urandom));
    end
    send_request(MODE_READ, PORT_ADDR, DataW'($urandom));
  endtask

  task automatic run_random(input int unsigned stop_at);
    int unsigned pick;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_request(MODE_WRITE, PORT_ADDR, pick_addr());
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(1)) send_request(MODE_WRITE, PORT_DATA, DataW'($urandom));
          else send_request(MODE_READ, PORT_DATA, DataW'($urandom));
        end
      end else if (pick < 45) begin
        repeat ($urandom_range(1, 4)) send_request(MODE_READ, 1'($urandom), DataW'($urandom));
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 40)) send_request(MODE_TICK, 1'($urandom), DataW'($urandom));
      end else if (pick < 80) begin
        run_timers();
      end else if (pick < 90) begin
        send_request(2'($urandom), 1'($urandom), DataW'($urandom));
      end else begin
        send_request(MODE_WRITE, 1'($urandom), DataW'($urandom));
        send_request(MODE_READ, PORT_ADDR, DataW'($urandom));
      end
    end
  endtask

  initial begin
    req_if.valid <= 1'b0;
    req_if.mode <= MODE_TICK;
    req_if.port_select <= PORT_ADDR;
    req_if.data <= '0;
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(MODE_READ, PORT_ADDR, 8'h00);
    send_request(MODE_READ, PORT_DATA, 8'hFF);
    write_reg(8'hFF, 8'hFF);
    send_request(MODE_READ, PORT_DATA, 8'h00);
    send_request(MODE_READ, PORT_ADDR, 8'h00);
    send_request(ModeUnused, PORT_DATA, 8'hAA);
    write_reg(8'h00, 8'h5A);
    send_request(MODE_READ, PORT_DATA, 8'h00);
    write_reg(RegTimerOne, 8'hFF);
    write_reg(RegTimerTwo, 8'h00);
    write_reg(RegTimerCtrl, 8'h03);
    write_reg(RegTimerOne, 8'hFE);
    send_request(MODE_TICK, PORT_DATA, 8'hFF);
    write_reg(RegTimerCtrl, 8'hE0);
    send_request(MODE_READ, PORT_DATA, 8'h00);
    send_request(MODE_READ, PORT_ADDR, 8'h00);
    drain_reads();

    for (int p = 0; p < RandPhases; p++) begin
      send_idle_pct = (p == 0) ? 26 : (p == 1) ? 61 : 0;
      recv_idle_pct = (p == 0) ? 61 : (p == 1) ? 26 : 0;
      run_random(items_sent + ItemTarget / RandPhases);
      drain_reads();
    end

    repeat (4) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("fm_chip_timer_register_file_tb passed");
    end else begin
      $display("fm_chip_timer_register_file_tb failed");
    end
    $finish;
  end

endmodule
